// File: rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list engine package
// Shared sizes, action codes, result type and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [1:0] {
    ACT_INS_FRONT = 2'd0,
    ACT_INS_BACK  = 2'd1,
    ACT_DELETE    = 2'd2,
    ACT_NONE      = 2'd3
  } ile_action_e;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                     last;
    logic                     empty_res;
    logic                     dropped;
  } ile_res_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // latch the accepted item
    logic ins_front;   // write at the slot before the front
    logic ins_back;    // write at the slot after the back
    logic pop_front;   // advance the front pointer
    logic shift_init;  // start the close-up at the deleted position
    logic shift_rd;    // read the entry behind the current one
    logic shift_wr;    // write the read entry one place forward
    logic shrink;      // drop one element from the count
    logic drop;        // flag this item's insert as refused
    logic dump_init;   // rewind the dump index
    logic dump_rd;     // issue one dump read
  } ile_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_insert;
    logic is_front_ins;
    logic is_delete;
    logic full;
    logic del_ok;
    logic del_front;
    logic del_tail;
    logic shift_more;
    logic dump_last;
  } ile_status_t;

endpackage

`default_nettype wire

// File: rtl/ile_if.sv
// ----------------------------------------------------------------------------
// Indexed list engine channels
// Valid/ready channel interfaces for the input items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ile_in_if;
  import ile_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic signed [DATA_W-1:0] operand;

  modport source (output valid, action, operand, input ready);
  modport sink   (input valid, action, operand, output ready);
endinterface

interface ile_out_if;
  import ile_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element;
  logic                     last;
  logic                     empty_res;
  logic                     dropped;

  modport source (output valid, element, last, empty_res, dropped, input ready);
  modport sink   (input valid, element, last, empty_res, dropped, output ready);
endinterface

`default_nettype wire

// File: rtl/ile_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed list engine controller
// Sequences one item: decode, optional close-up after a delete, then the dump.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ile_pkg::ile_status_t status_i,
  input  wire logic                credit_i,
  output ile_pkg::ile_cmd_t        cmd_o
);
  import ile_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SH_RD,
    S_SH_WR,
    S_DUMP
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && rdy_q) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.is_insert) begin
          if (status_i.full) begin
            cmd_o.drop = 1'b1;
          end else if (status_i.is_front_ins) begin
            cmd_o.ins_front = 1'b1;
          end else begin
            cmd_o.ins_back = 1'b1;
          end
          cmd_o.dump_init = 1'b1;
          state_d         = S_DUMP;
        end else if (status_i.is_delete && status_i.del_ok) begin
          if (status_i.del_front) begin
            cmd_o.pop_front = 1'b1;
            cmd_o.dump_init = 1'b1;
            state_d         = S_DUMP;
          end else if (status_i.del_tail) begin
            cmd_o.shrink    = 1'b1;
            cmd_o.dump_init = 1'b1;
            state_d         = S_DUMP;
          end else begin
            cmd_o.shift_init = 1'b1;
            state_d          = S_SH_RD;
          end
        end else begin
          cmd_o.dump_init = 1'b1;
          state_d         = S_DUMP;
        end
      end
      S_SH_RD: begin
        cmd_o.shift_rd = 1'b1;
        state_d        = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.shift_wr = 1'b1;
        if (status_i.shift_more) begin
          state_d = S_SH_RD;
        end else begin
          cmd_o.shrink    = 1'b1;
          cmd_o.dump_init = 1'b1;
          state_d         = S_DUMP;
        end
      end
      S_DUMP: begin
        if (credit_i) begin
          cmd_o.dump_rd = 1'b1;
          if (status_i.dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = rdy_q;

endmodule

`default_nettype wire

// File: rtl/ile_dp.sv
// ----------------------------------------------------------------------------
// Indexed list engine datapath
// Ring store with front pointer and occupancy, item latch and dump read pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ile_pkg::ile_cmd_t         cmd_i,
  input  wire logic [1:0]                item_action_i,
  input  wire logic signed [31:0]        item_operand_i,
  output ile_pkg::ile_status_t           status_o,
  output logic                           push_valid_o,
  output ile_pkg::ile_res_t              push_o
);
  import ile_pkg::*;

  typedef logic [IDX_W:0] off_t;
  typedef logic [CNT_W:0] wide_t;

  function automatic idx_t ring_at(idx_t base, off_t off);
    off_t sum;
    sum = {1'b0, base} + off;
    if (sum >= off_t'(CAPACITY)) begin
      sum = sum - off_t'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic signed [DATA_W-1:0] mem_q [CAPACITY];
  logic signed [DATA_W-1:0] rdata_q;
  logic [1:0]               act_q;
  logic signed [DATA_W-1:0] opnd_q;
  idx_t                     front_q, front_d;
  cnt_t                     occ_q, occ_d;
  idx_t                     k_q, k_d;
  logic                     drop_q, drop_d;
  logic                     tag_vld_q, tag_last_q, tag_empty_q, tag_drop_q;

  idx_t                     pos_idx;
  idx_t                     front_m1;
  logic                     wr_en, rd_en;
  idx_t                     wr_addr, rd_addr;
  logic signed [DATA_W-1:0] wr_data;

  assign pos_idx  = opnd_q[IDX_W-1:0];
  assign front_m1 = (front_q == '0) ? idx_t'(CAPACITY - 1) : front_q - 1'b1;

  // Decode the latched item
  always_comb begin
    status_o              = '0;
    status_o.is_insert    = (act_q == ACT_INS_FRONT) || (act_q == ACT_INS_BACK);
    status_o.is_front_ins = (act_q == ACT_INS_FRONT);
    status_o.is_delete    = (act_q == ACT_DELETE);
    status_o.full         = (occ_q == cnt_t'(CAPACITY));
    status_o.del_ok       = !opnd_q[DATA_W-1] &&
                            ($unsigned(opnd_q) < DATA_W'(occ_q));
    status_o.del_front    = (opnd_q == '0);
    status_o.del_tail     = (wide_t'(pos_idx) + wide_t'(1) == wide_t'(occ_q));
    status_o.shift_more   = (wide_t'(k_q) + wide_t'(2) < wide_t'(occ_q));
    status_o.dump_last    = (occ_q == '0) ||
                            (wide_t'(k_q) + wide_t'(1) == wide_t'(occ_q));
  end

  // Store ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = front_m1;
    wr_data = opnd_q;
    if (cmd_i.ins_front) begin
      wr_en = 1'b1;
    end else if (cmd_i.ins_back) begin
      wr_en   = 1'b1;
      wr_addr = ring_at(front_q, off_t'(occ_q));
    end else if (cmd_i.shift_wr) begin
      wr_en   = 1'b1;
      wr_addr = ring_at(front_q, off_t'(k_q));
      wr_data = rdata_q;
    end
    rd_en   = cmd_i.shift_rd || (cmd_i.dump_rd && (occ_q != '0));
    rd_addr = cmd_i.shift_rd ? ring_at(front_q, off_t'(k_q) + off_t'(1))
                             : ring_at(front_q, off_t'(k_q));
  end

  // Pointer, count and index updates
  always_comb begin
    front_d = front_q;
    occ_d   = occ_q;
    k_d     = k_q;
    drop_d  = drop_q;
    if (cmd_i.load) begin
      drop_d = 1'b0;
    end
    if (cmd_i.drop) begin
      drop_d = 1'b1;
    end
    if (cmd_i.ins_front) begin
      front_d = front_m1;
      occ_d   = occ_q + 1'b1;
    end
    if (cmd_i.ins_back) begin
      occ_d = occ_q + 1'b1;
    end
    if (cmd_i.pop_front || cmd_i.shrink) begin
      occ_d = occ_q - 1'b1;
      if (occ_q == cnt_t'(1)) begin
        front_d = '0;
      end else if (cmd_i.pop_front) begin
        front_d = ring_at(front_q, off_t'(1));
      end
    end
    if (cmd_i.shift_init) begin
      k_d = pos_idx;
    end
    if (cmd_i.shift_wr || cmd_i.dump_rd) begin
      k_d = k_q + 1'b1;
    end
    if (cmd_i.dump_init) begin
      k_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      occ_q     <= '0;
      k_q       <= '0;
      drop_q    <= 1'b0;
      tag_vld_q <= 1'b0;
    end else begin
      front_q   <= front_d;
      occ_q     <= occ_d;
      k_q       <= k_d;
      drop_q    <= drop_d;
      tag_vld_q <= cmd_i.dump_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= item_action_i;
      opnd_q <= item_operand_i;
    end
    if (cmd_i.dump_rd) begin
      tag_last_q  <= status_o.dump_last;
      tag_empty_q <= (occ_q == '0);
      tag_drop_q  <= drop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign push_valid_o     = tag_vld_q;
  assign push_o.element   = tag_empty_q ? '0 : rdata_q;
  assign push_o.last      = tag_last_q;
  assign push_o.empty_res = tag_empty_q;
  assign push_o.dropped   = tag_drop_q;

endmodule

`default_nettype wire

// File: rtl/ile_outq.sv
// ----------------------------------------------------------------------------
// Indexed list engine result queue
// Two-entry result buffer; grants a read credit only when its data has room.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  input  wire ile_pkg::ile_res_t push_i,
  output logic                   credit_o,
  ile_out_if.source              result_o
);
  import ile_pkg::*;

  ile_res_t   buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;
  ile_res_t   head;

  assign pop  = result_o.valid && result_o.ready;
  assign head = buf_q[rd_ptr_q];

  // Space for one more read in flight once pushes and pops settle
  assign credit_o = ({1'b0, cnt_q} + 3'(push_valid_i)) < (3'd2 + 3'(pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_valid_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_valid_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i) begin
      buf_q[wr_ptr_q] <= push_i;
    end
  end

  assign result_o.valid     = (cnt_q != '0);
  assign result_o.element   = head.element;
  assign result_o.last      = head.last;
  assign result_o.empty_res = head.empty_res;
  assign result_o.dropped   = head.dropped;

endmodule

`default_nettype wire

// File: rtl/indexed_list_engine_core.sv
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of signed 32-bit values in a 32-entry ring store; each item
// inserts at the front or back, deletes by position, or leaves the list be,
// and is answered by a dump of the whole list.
// ----------------------------------------------------------------------------
// Usage
//   item_i   : action and operand; a transfer happens when valid and ready
//              are high at a rising edge. Ready is high whenever the
//              controller sits idle.
//   result_o : one transfer per list element, front to back, last set on the
//              final one; an empty list gives one transfer with empty_res set
//              and element zero. dropped marks every result of an insert
//              refused because the list was full.
//   Order    : after the item transfer the controller decodes it, runs the
//              close-up below if any, then issues the dump reads.
//   Rate     : one result per cycle while the receiver takes them; the next
//              item is taken only once the dump has issued its last read.
//              A delete in the middle reads then writes each element behind
//              the deleted one, one after the other, to close the gap. The
//              list dump is paced by the read credits of the result queue.
//   Stall    : a two-entry result queue holds results; when it fills, the
//              dump reads pause and resume without loss.
//   Reset    : empties the list at once; no clearing pass over the store.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ile_in_if.sink    item_i,
  ile_out_if.source result_o
);
  import ile_pkg::*;

  ile_cmd_t    cmd;
  ile_status_t status;
  ile_res_t    push;
  logic        push_valid;
  logic        credit;
  logic        in_ready;

  // Sequence the item: decode, close up, dump
  ile_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .credit_i   (credit),
    .cmd_o      (cmd)
  );

  assign item_i.ready = in_ready;

  // Hold the ring store, pointers and the read pipe
  ile_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_action_i  (item_i.action),
    .item_operand_i (item_i.operand),
    .status_o       (status),
    .push_valid_o   (push_valid),
    .push_o         (push)
  );

  // Buffer results against a stalling receiver
  ile_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_i       (push),
    .credit_o     (credit),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire

// File: rtl/ile_checker.sv
// ----------------------------------------------------------------------------
// Indexed list engine checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic [31:0] element_i,
  input wire logic        last_i,
  input wire logic        empty_i,
  input wire logic        dropped_i
);

  // Hold a result until it is taken
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result valid dropped before transfer");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> $stable(element_i) && $stable(last_i) &&
                            $stable(empty_i) && $stable(dropped_i))
    else $error("result payload changed while stalled");

  // An empty list answers with a single zero result
  a_empty_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && empty_i |-> last_i && (element_i == 32'd0))
    else $error("empty result not last or not zero");

  // The refused flag is the same on every result of one dump
  a_drop_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_i && !last_i ##1 valid_i |-> dropped_i == $past(dropped_i))
    else $error("dropped flag changed within one dump");

endmodule

bind indexed_list_engine_core ile_checker u_ile_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .valid_i   (result_o.valid),
  .ready_i   (result_o.ready),
  .element_i (result_o.element),
  .last_i    (result_o.last),
  .empty_i   (result_o.empty_res),
  .dropped_i (result_o.dropped)
);

`default_nettype wire
